[rtl/core/fdm_pkg.sv]
// Shared types and constants of the multichannel frequency and duty-cycle meter.
package fdm_pkg;

    localparam int PIN_W      = 8;
    localparam int CNT_W      = 16;
    localparam int RATE_W     = 27;
    localparam int CHCNT_W    = 4;
    localparam int FREQ_W     = 29;
    localparam int DUTY_W     = 10;
    localparam int CHAN_W     = 3;
    localparam int PROD_W     = CNT_W + RATE_W;
    localparam int DIV_W      = PROD_W + 4;
    localparam int DNUM_W     = 26;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [CNT_W-1:0]   WINDOW_RESET = 16'd1000;
    localparam logic [RATE_W-1:0]  RATE_RESET   = 27'd10000;
    localparam logic [CHCNT_W-1:0] CHCNT_RESET  = 4'd8;
    localparam logic [DUTY_W-1:0]  DUTY_MAX     = 10'd1000;
    localparam logic [FREQ_W-1:0]  FREQ_MAX     = '1;
    localparam logic [9:0]         DUTY_SCALE   = 10'd1000;

    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    localparam logic [1:0] REG_WINDOW_TICKS  = 2'd0;
    localparam logic [1:0] REG_TICK_RATE_HZ  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [PIN_W-1:0]  pin_levels;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [FREQ_W-1:0] freq_deci_hz;
        logic [DUTY_W-1:0] duty_deci_pct;
        logic              last_of_burst;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]   window_ticks;
        logic [RATE_W-1:0]  tick_rate_hz;
        logic [CHCNT_W-1:0] channel_count;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic restart;
        logic ch_first;
        logic prod;
        logic scale;
        logic div_start;
        logic div_sel_d;
        logic cap_f;
        logic out_load;
        logic ch_next;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic req_restart;
        logic close;
        logic div_idle;
        logic out_free;
        logic last_ch;
    } t_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_SCALE,
        S_DIVF,
        S_DIVF_W,
        S_DIVD,
        S_DIVD_W,
        S_EMIT
    } t_state;

endpackage

[rtl/core/fdm_div.sv]
// Restoring divider, one quotient bit per cycle.
module fdm_div import fdm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_num,
    input  logic [CNT_W-1:0]  i_den,
    output logic              o_idle,
    output logic [DIV_W-1:0]  o_quot
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_den;
    logic [DIV_W-1:0]     r_acc;

    logic [CNT_W:0]       rem_sh;
    logic [CNT_W:0]       rem_sub;
    logic                 ge;

    assign rem_sh  = {r_rem, r_acc[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_acc <= {r_acc[DIV_W-2:0], ge};
            r_rem <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    assign o_idle = !r_busy;
    assign o_quot = r_acc;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with no steps left");

endmodule

[rtl/core/fdm_dp.sv]
// Datapath: per-channel counters, scaling, shared divider and result register.
module fdm_dp import fdm_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_in_item   i_in_data,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_data
);

    localparam int NCH = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;
    localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;

    logic [PIN_W-1:0]  r_prev;
    logic [CNT_W-1:0]  r_ticks;
    logic [CNT_W-1:0]  r_high [NCH];
    logic [CNT_W-1:0]  r_rise [NCH];
    logic [CHW-1:0]    r_ch;
    logic [PROD_W-1:0] r_fprod;
    logic [DNUM_W-1:0] r_dnum;
    logic [DIV_W-1:0]  r_fnum;
    logic [FREQ_W-1:0] r_freq;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [CNT_W-1:0]   n_ticks;
    logic [CNT_W-1:0]   win;
    logic [CNT_W-2:0]   half;
    logic [CHCNT_W-1:0] act;
    logic [DIV_W-1:0]   div_num;
    logic [DIV_W-1:0]   quot;
    logic               div_idle;
    logic [DUTY_W-1:0]  duty;
    logic               out_free;
    logic               last_ch;

    assign n_ticks = r_ticks + 1'b1;
    assign win     = (i_cfg.window_ticks == '0) ? CNT_W'(1) : i_cfg.window_ticks;
    assign half    = r_ticks[CNT_W-1:1];

    always_comb begin
        if (i_cfg.channel_count == '0) begin
            act = CHCNT_W'(1);
        end else if (i_cfg.channel_count > CHCNT_W'(NCH)) begin
            act = CHCNT_W'(NCH);
        end else begin
            act = i_cfg.channel_count;
        end
    end

    assign last_ch  = (CHCNT_W'(r_ch) + 1'b1) == act;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_ticks <= '0;
        end else if (i_cmd.restart) begin
            r_prev  <= i_in_data.pin_levels;
            r_ticks <= '0;
        end else if (i_cmd.tick) begin
            r_prev  <= i_in_data.pin_levels;
            r_ticks <= n_ticks;
        end else if (i_cmd.clear) begin
            r_ticks <= '0;
        end
    end

    for (genvar g = 0; g < NCH; g++) begin : g_ch
        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_cmd.restart || i_cmd.clear) begin
                r_high[g] <= '0;
                r_rise[g] <= '0;
            end else if (i_cmd.tick) begin
                if (i_in_data.pin_levels[g]) begin
                    r_high[g] <= r_high[g] + 1'b1;
                end
                if (i_in_data.pin_levels[g] && !r_prev[g]) begin
                    r_rise[g] <= r_rise[g] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (i_cmd.ch_first) begin
            r_ch <= '0;
        end else if (i_cmd.ch_next) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod) begin
            r_fprod <= PROD_W'(r_rise[r_ch] * i_cfg.tick_rate_hz);
            r_dnum  <= DNUM_W'(r_high[r_ch] * DUTY_SCALE) + DNUM_W'(half);
        end
        if (i_cmd.scale) begin
            r_fnum <= {r_fprod, 3'b000} + {2'b00, r_fprod, 1'b0} + DIV_W'(half);
        end
        if (i_cmd.cap_f) begin
            r_freq <= (|quot[DIV_W-1:FREQ_W]) ? FREQ_MAX : quot[FREQ_W-1:0];
        end
    end

    assign div_num = i_cmd.div_sel_d ? DIV_W'(r_dnum) : r_fnum;

    fdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_ticks),
        .o_idle  (div_idle),
        .o_quot  (quot)
    );

    assign duty = (quot > DIV_W'(DUTY_MAX)) ? DUTY_MAX : quot[DUTY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.channel       <= CHAN_W'(r_ch);
            r_out.freq_deci_hz  <= (i_cfg.tick_rate_hz == '0) ? '0 : r_freq;
            r_out.duty_deci_pct <= (i_cfg.tick_rate_hz == '0) ? '0 : duty;
            r_out.last_of_burst <= last_ch;
        end
    end

    always_comb begin
        o_sts.req_restart = i_in_data.req_type == REQ_RESTART;
        o_sts.close       = n_ticks >= win;
        o_sts.div_idle    = div_idle;
        o_sts.out_free    = out_free;
        o_sts.last_ch     = last_ch;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_load_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (div_idle && out_free))
        else $error("result loaded while divider busy or output full");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.duty_deci_pct <= DUTY_MAX))
        else $error("duty result out of range");

endmodule

[rtl/core/fdm_ctrl.sv]
// Controller: sequences counting, per-channel scaling, division and result hand-off.
module fdm_ctrl import fdm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_sts.req_restart && i_sts.close) begin
                    n_state = S_PROD;
                end
            end
            S_PROD:   n_state = S_SCALE;
            S_SCALE:  n_state = S_DIVF;
            S_DIVF:   n_state = S_DIVF_W;
            S_DIVF_W: begin
                if (i_sts.div_idle) begin
                    n_state = S_DIVD;
                end
            end
            S_DIVD:   n_state = S_DIVD_W;
            S_DIVD_W: begin
                if (i_sts.div_idle) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.last_ch ? S_IDLE : S_PROD;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.restart  = i_sts.req_restart;
                    o_cmd.tick     = !i_sts.req_restart;
                    o_cmd.ch_first = !i_sts.req_restart && i_sts.close;
                end
            end
            S_PROD:   o_cmd.prod = 1'b1;
            S_SCALE:  o_cmd.scale = 1'b1;
            S_DIVF:   o_cmd.div_start = 1'b1;
            S_DIVF_W: o_cmd.cap_f = i_sts.div_idle;
            S_DIVD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_d = 1'b1;
            end
            S_DIVD_W: o_cmd.div_sel_d = 1'b1;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = i_sts.last_ch;
                    o_cmd.ch_next  = !i_sts.last_ch;
                end
            end
            default:  o_cmd = '0;
        endcase
    end

    a_close_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && !i_sts.req_restart && i_sts.close)
        |=> (r_state == S_PROD))
        else $error("closing tick did not start the burst");

endmodule

[rtl/core/multichannel_freq_duty_meter.sv]
// Multichannel frequency and duty-cycle meter: configuration registers and core wiring.
// A restart or a tick that does not close the window does not stall; the next is taken at once.
// A window-closing tick holds off input until every active channel is done; the 47-step
// shared divider runs twice per channel (frequency, then duty).
// The next channel is divided while a finished result waits in the output register.
// Synchronous active-low reset: counters, levels and tick count clear; registers take defaults.
module multichannel_freq_duty_meter import fdm_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [CNT_W-1:0]   r_window_ticks;
    logic [RATE_W-1:0]  r_tick_rate_hz;
    logic [CHCNT_W-1:0] r_channel_count;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks  <= WINDOW_RESET;
            r_tick_rate_hz  <= RATE_RESET;
            r_channel_count <= CHCNT_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_WINDOW_TICKS:  r_window_ticks  <= pwdata[CNT_W-1:0];
                REG_TICK_RATE_HZ:  r_tick_rate_hz  <= pwdata[RATE_W-1:0];
                REG_CHANNEL_COUNT: r_channel_count <= pwdata[CHCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WINDOW_TICKS:  prdata = DATA_W'(r_window_ticks);
            REG_TICK_RATE_HZ:  prdata = DATA_W'(r_tick_rate_hz);
            REG_CHANNEL_COUNT: prdata = DATA_W'(r_channel_count);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        cfg.window_ticks  = r_window_ticks;
        cfg.tick_rate_hz  = r_tick_rate_hz;
        cfg.channel_count = r_channel_count;
    end

    fdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    fdm_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
